// ===== hdl/trle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
`default_nettype none
package trle_pkg;

  // Default width of the image pixel counters.
  localparam int TRLE_COUNT_WIDTH = 25;

  // Configuration register indexes.
  localparam int TRLE_CFG_INDEX_W = 2;
  typedef enum logic [TRLE_CFG_INDEX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 2'd0,
    CFG_PIXEL_COUNT     = 2'd1
  } trle_cfg_idx_t;

  // Reset value of the pixel-size configuration register.
  localparam logic [2:0] TRLE_BPP_RESET = 3'd4;

  // Packet header coding.
  localparam logic [7:0] TRLE_RUN_BIAS = 8'd127;

  // Width of the packed result beat.
  localparam int TRLE_TDATA_OUT_W = 48;

  // One decoded result.
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  repeat_res;
    logic        last;
    logic        overrun;
  } trle_result_t;

endpackage : trle_pkg
`default_nettype wire

// ===== hdl/tga_rle_pixel_decoder.sv =====
// Top level of the TGA run-length pixel decoder.
// Takes one byte of a run-length-coded TGA image body per beat and gives one
// beat per completed pixel: the packed pixel, its repeat count, an overrun flag
// and tlast on the final pixel of the image. A byte with s_tuser high starts a
// new image and is read as its first packet header. One byte is taken every
// clock cycle when the output side keeps up; a byte passes an input register,
// then the decoder state step, then the result register, which drives m_tvalid.
// The state step is the only loop. Configuration is taken at any time but should
// only change while the block is idle.
`default_nettype none
module tga_rle_pixel_decoder #(
  parameter int COUNT_WIDTH = trle_pkg::TRLE_COUNT_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Input byte stream.
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [7:0]                            s_tdata,   // [7:0] data_byte
  input  wire logic                                  s_tuser,   // [0] first
  // Decoded pixel stream.
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [trle_pkg::TRLE_TDATA_OUT_W-1:0]      m_tdata,   // [31:0] pixel,
                                                                // [39:32] repeat_res,
                                                                // [40] overrun
  output logic                                       m_tlast,
  // Configuration writes.
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [trle_pkg::TRLE_CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COUNT_WIDTH-1:0]                cfg_data
);
  import trle_pkg::*;

  logic [2:0]             bytes_per_pixel;
  logic [COUNT_WIDTH-1:0] pixel_count;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_first;
  logic         out_valid;
  trle_result_t out_res;
  logic         out_free;
  logic         step;
  logic         res_valid;
  trle_result_t res;

  trle_cfg #(.COUNT_WIDTH(COUNT_WIDTH)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .bytes_per_pixel (bytes_per_pixel),
    .pixel_count     (pixel_count)
  );

  // Handshake between the stages.
  assign out_free = !out_valid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  trle_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (in_byte),
    .first           (in_first),
    .bytes_per_pixel (bytes_per_pixel),
    .pixel_count     (pixel_count),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  // Pack the result beat.
  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {{(TRLE_TDATA_OUT_W-41){1'b0}}, out_res.overrun,
                     out_res.repeat_res, out_res.pixel};

endmodule : tga_rle_pixel_decoder
`default_nettype wire

// ===== hdl/trle_cfg.sv =====
// Configuration registers: pixel size and image pixel count.
`default_nettype none
module trle_cfg #(
  parameter int COUNT_WIDTH = trle_pkg::TRLE_COUNT_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [trle_pkg::TRLE_CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COUNT_WIDTH-1:0]              cfg_data,
  output logic [2:0]                               bytes_per_pixel,
  output logic [COUNT_WIDTH-1:0]                   pixel_count
);
  import trle_pkg::*;

  // Always take a write beat.
  assign cfg_ready = 1'b1;

  // Hold register values; load the addressed one on a write beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= TRLE_BPP_RESET;
      pixel_count     <= {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end else if (cfg_valid) begin
      case (trle_cfg_idx_t'(cfg_index))
        CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        CFG_PIXEL_COUNT:     pixel_count     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule : trle_cfg
`default_nettype wire

// ===== hdl/trle_core.sv =====
// Decoder state and per-byte step logic: packet headers, pixel assembly, clipping.
`default_nettype none
module trle_core #(
  parameter int COUNT_WIDTH = trle_pkg::TRLE_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   first,
  input  wire logic [2:0]             bytes_per_pixel,
  input  wire logic [COUNT_WIDTH-1:0] pixel_count,
  output logic                        res_valid,
  output trle_pkg::trle_result_t      res
);
  import trle_pkg::*;

  logic                   expect_header, expect_header_next;
  logic                   run_packet, run_packet_next;
  logic [7:0]             packet_left, packet_left_next;
  logic [1:0]             byte_index, byte_index_next;
  logic [31:0]            pixel_shift, pixel_shift_next;
  logic [COUNT_WIDTH-1:0] pixels_done, pixels_done_next;
  logic                   image_ended, image_ended_next;

  // Index of the final byte of a pixel; out-of-range sizes saturate.
  logic [1:0] bpp_last;
  always_comb begin
    case (bytes_per_pixel)
      3'd0, 3'd1: bpp_last = 2'd0;
      3'd2:       bpp_last = 2'd1;
      3'd3:       bpp_last = 2'd2;
      default:    bpp_last = 2'd3;
    endcase
  end

  // Image size, zero treated as one.
  logic [COUNT_WIDTH-1:0] total;
  assign total = (pixel_count == '0) ? {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : pixel_count;

  // Work out the next state and the result for one byte.
  always_comb begin
    logic                   eh;
    logic [1:0]             bi;
    logic [31:0]            ps;
    logic [COUNT_WIDTH-1:0] pd;
    logic [COUNT_WIDTH-1:0] remaining;
    logic [7:0]             n;
    logic [7:0]             pl_after;
    logic                   is_last;

    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    packet_left_next   = packet_left;
    byte_index_next    = byte_index;
    pixel_shift_next   = pixel_shift;
    pixels_done_next   = pixels_done;
    image_ended_next   = image_ended;
    res_valid          = 1'b0;
    res                = '0;

    // A start marker clears the image state.
    eh = first ? 1'b1 : expect_header;
    bi = first ? 2'd0 : byte_index;
    ps = first ? 32'd0 : pixel_shift;
    pd = first ? '0 : pixels_done;

    remaining = (total > pd) ? (total - pd) : '0;

    n = run_packet ? packet_left : 8'd1;
    if (n == 8'd0) n = 8'd1;
    if (COUNT_WIDTH'(n) > remaining) n = remaining[7:0];
    pl_after = (packet_left >= n) ? (packet_left - n) : 8'd0;
    is_last  = (COUNT_WIDTH'(n) == remaining);

    if (first || !image_ended) begin
      image_ended_next = 1'b0;
      pixels_done_next = pd;
      if (eh) begin
        // Packet header: raw packets count header+1, runs header-127.
        run_packet_next    = data_byte[7];
        packet_left_next   = data_byte[7] ? (data_byte - TRLE_RUN_BIAS) : (data_byte + 8'd1);
        expect_header_next = 1'b0;
        byte_index_next    = 2'd0;
        pixel_shift_next   = 32'd0;
      end else begin
        expect_header_next = 1'b0;
        // Place the byte into the pixel being assembled.
        case (bi)
          2'd0:    ps = ps | {24'd0, data_byte};
          2'd1:    ps = ps | {16'd0, data_byte, 8'd0};
          2'd2:    ps = ps | {8'd0, data_byte, 16'd0};
          default: ps = ps | {data_byte, 24'd0};
        endcase
        if (bi < bpp_last) begin
          byte_index_next  = bi + 2'd1;
          pixel_shift_next = ps;
        end else if (remaining == '0) begin
          // Image already full: drop the pixel and end.
          image_ended_next = 1'b1;
          byte_index_next  = 2'd0;
          pixel_shift_next = 32'd0;
        end else begin
          // Pixel complete: emit it with its repeat count.
          res_valid          = 1'b1;
          res.pixel          = ps;
          res.repeat_res     = n;
          res.last           = is_last;
          res.overrun        = is_last && (pl_after != 8'd0);
          packet_left_next   = pl_after;
          pixels_done_next   = pd + COUNT_WIDTH'(n);
          byte_index_next    = 2'd0;
          pixel_shift_next   = 32'd0;
          expect_header_next = (pl_after == 8'd0);
          image_ended_next   = is_last;
        end
      end
    end
  end

  // Advance state on each processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= 8'd0;
      byte_index    <= 2'd0;
      pixel_shift   <= 32'd0;
      pixels_done   <= '0;
      image_ended   <= 1'b1;
    end else if (step) begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      packet_left   <= packet_left_next;
      byte_index    <= byte_index_next;
      pixel_shift   <= pixel_shift_next;
      pixels_done   <= pixels_done_next;
      image_ended   <= image_ended_next;
    end
  end

endmodule : trle_core
`default_nettype wire

// ===== hdl/trle_checker.sv =====
// Port-level checks for the TGA run-length pixel decoder, bound to the top level.
`default_nettype none
module trle_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_tready,
  input wire logic                                  m_tvalid,
  input wire logic                                  m_tready,
  input wire logic [trle_pkg::TRLE_TDATA_OUT_W-1:0] m_tdata,
  input wire logic                                  m_tlast
);

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown right after reset");

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

  // Overrun only on the final pixel of an image.
  a_overrun_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |-> m_tlast)
    else $error("overrun without last");

  // Repeat count stays within one packet.
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
    else $error("repeat count out of range");

  // Take input bytes whenever the result side is empty.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule : trle_checker

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
`default_nettype wire
